FILE: rtl/core/cgm_pkg.sv
// Shared types and constants of the conservative grid metrics block.
`timescale 1ns / 1ps
package cgm_pkg;

  localparam int unsigned IDX_W    = 5;
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned METRIC_W = 48;
  localparam int unsigned DIM_W    = 6;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_DEGEN = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DIM_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Z = 2'd2;

  typedef struct packed {
    logic                      opcode;
    logic [IDX_W-1:0]          node_i;
    logic [IDX_W-1:0]          node_j;
    logic [IDX_W-1:0]          node_k;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic signed [METRIC_W-1:0] inv_jacobian;
    logic signed [METRIC_W-1:0] xi_dx;
    logic signed [METRIC_W-1:0] xi_dy;
    logic signed [METRIC_W-1:0] xi_dz;
    logic signed [METRIC_W-1:0] eta_dx;
    logic signed [METRIC_W-1:0] eta_dy;
    logic signed [METRIC_W-1:0] eta_dz;
    logic signed [METRIC_W-1:0] zeta_dx;
    logic signed [METRIC_W-1:0] zeta_dy;
    logic signed [METRIC_W-1:0] zeta_dz;
    logic [1:0]                 status;
  } out_item_t;

endpackage

FILE: rtl/core/conservative_grid_metrics.sv
// Conservative grid metrics: coordinate store, metric sequencer and divider.
`timescale 1ns / 1ps
// A load item writes one node's coordinates into the coordinate store and gives no
// result. For a query item, each of the nine cofactors is built from eight coordinate
// products that need three store reads each, followed by two reads for the matching
// derivative, all through the store's single read port and one shared 35 by 35
// multiplier; then ten restoring divisions give 1/J and the nine scaled metrics.
// Queries that are out of range skip this work and answer with a range status. The
// store has no clearing pass: a node must be loaded before a query reads it. A
// finished item may wait in the output register while the next item is taken.
module conservative_grid_metrics (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  cgm_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output cgm_pkg::out_item_t            out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cgm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [cgm_pkg::DIM_W-1:0]     cfg_data_i
);
  import cgm_pkg::*;

  typedef logic [2:0][IDX_W-1:0] pos_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_T_RQ, ST_T_RP, ST_T_RM, ST_T_DIF, ST_T_MUL, ST_T_ACC,
    ST_D_RP, ST_D_RM, ST_D_DIF, ST_D_ML, ST_D_MH, ST_D_SA, ST_ZCHK,
    ST_V_SET, ST_V_CHK, ST_V_IT, ST_V_FIN, ST_DONE
  } state_e;

  function automatic logic [1:0] ax_next(input logic [1:0] a);
    return (a == 2'd2) ? 2'd0 : a + 2'd1;
  endfunction

  function automatic logic [1:0] ax_prev(input logic [1:0] a);
    return (a == 2'd0) ? 2'd2 : a - 2'd1;
  endfunction

  function automatic pos_t pos_step(input pos_t p, input logic [1:0] axis, input logic up);
    pos_t r;
    r = p;
    case (axis)
      2'd0: r[0] = up ? p[0] + 5'd1 : p[0] - 5'd1;
      2'd1: r[1] = up ? p[1] + 5'd1 : p[1] - 5'd1;
      default: r[2] = up ? p[2] + 5'd1 : p[2] - 5'd1;
    endcase
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] sel_comp(input logic [3*COORD_W-1:0] e,
                                                 input logic [1:0] c);
    case (c)
      2'd0: return e[COORD_W-1:0];
      2'd1: return e[2*COORD_W-1:COORD_W];
      default: return e[3*COORD_W-1:2*COORD_W];
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    if (v < 6'd3) return 6'd3;
    if (v > 6'd32) return 6'd32;
    return v;
  endfunction

  // Coordinate store, {z, y, x} per node, addressed by {k, j, i}.
  logic [3*COORD_W-1:0] mem [32768];
  logic [3*COORD_W-1:0] rdata_q;
  logic [14:0]          raddr;

  state_e            state_q;
  logic [DIM_W-1:0]  dim_q [3];
  logic [1:0]        ax_q, comp_q;
  logic [2:0]        t_q;
  logic [3:0]        n_q, vi_q;
  logic [5:0]        cnt_q;
  logic [1:0]        stat_q;
  logic              out_valid_q;
  out_item_t         out_q;

  pos_t                 pos_q;
  logic [COORD_W-1:0]   xf_q, sp_q;
  logic signed [32:0]   d_q;
  logic signed [69:0]   prod_q;
  logic signed [67:0]   acc_q;
  logic signed [104:0]  s_q;
  logic signed [67:0]   cof_q [9];
  logic [111:0]         num_q;
  logic [47:0]          nsh_q;
  logic [105:0]         den_q;
  logic [105:0]         rem_q;
  logic [47:0]          quo_q;
  logic                 neg_q, huge_q;
  logic [METRIC_W-1:0]  res_q [10];

  function automatic logic rdata_q_bit(input logic [1:0] c);
    logic [COORD_W-1:0] v;
    v = sel_comp(rdata_q, c);
    return v[COORD_W-1];
  endfunction

  logic in_acc, out_acc;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign out_item_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // Query admission: range check and clamp onto the interior.
  logic [IDX_W-1:0] nidx [3];
  logic [DIM_W-1:0] edim [3];
  logic             oor;
  pos_t             cpos;
  always_comb begin
    nidx[0] = in_item_i.node_i;
    nidx[1] = in_item_i.node_j;
    nidx[2] = in_item_i.node_k;
    oor = 1'b0;
    for (int a = 0; a < 3; a++) begin
      edim[a] = eff_dim(dim_q[a]);
      if ({1'b0, nidx[a]} >= edim[a]) oor = 1'b1;
      if (nidx[a] == 5'd0) cpos[a] = 5'd1;
      else if ({1'b0, nidx[a]} > edim[a] - 6'd2) cpos[a] = 5'(edim[a] - 6'd2);
      else cpos[a] = nidx[a];
    end
  end

  // Decode of the current product term of the cofactor (ax_q, comp_q).
  logic [1:0] a_ax, b_ax, pc, qc, f_c, s_c, i_ax, o_ax, m;
  logic       dn, tneg, outer_a;
  pos_t       q_pos;
  always_comb begin
    a_ax    = ax_next(ax_q);
    b_ax    = ax_prev(ax_q);
    pc      = ax_next(comp_q);
    qc      = ax_prev(comp_q);
    m       = t_q[2:1];
    dn      = t_q[0];
    f_c     = m[1] ? qc : pc;
    s_c     = m[1] ? pc : qc;
    outer_a = (m == 2'd0) || (m == 2'd3);
    i_ax    = outer_a ? b_ax : a_ax;
    o_ax    = outer_a ? a_ax : b_ax;
    tneg    = m[0] ^ dn;
    q_pos   = pos_step(pos_q, o_ax, !dn);
    case (state_q)
      ST_T_RQ: raddr = q_pos;
      ST_T_RP: raddr = pos_step(q_pos, i_ax, 1'b1);
      ST_T_RM: raddr = pos_step(q_pos, i_ax, 1'b0);
      ST_D_RP: raddr = pos_step(pos_q, ax_q, 1'b1);
      ST_D_RM: raddr = pos_step(pos_q, ax_q, 1'b0);
      default: raddr = pos_q;
    endcase
  end

  logic signed [34:0] mul_a, mul_b;
  always_comb begin
    case (state_q)
      ST_D_ML: begin
        mul_a = {{2{d_q[32]}}, d_q};
        mul_b = {1'b0, acc_q[33:0]};
      end
      ST_D_MH: begin
        mul_a = {{2{d_q[32]}}, d_q};
        mul_b = {acc_q[67], acc_q[67:34]};
      end
      default: begin
        mul_a = {{3{xf_q[31]}}, xf_q};
        mul_b = {{2{d_q[32]}}, d_q};
      end
    endcase
  end

  // Divider operands.
  logic [104:0] smag;
  logic [67:0]  cmag;
  logic [69:0]  c3;
  logic signed [67:0] cur_c;
  logic [106:0] trial;
  logic         fits;
  logic [47:0]  qsat;
  always_comb begin
    smag  = s_q[104] ? 105'(-s_q) : 105'(s_q);
    cur_c = cof_q[vi_q - 4'd1];
    cmag  = cur_c[67] ? 68'(-cur_c) : 68'(cur_c);
    c3    = {2'b0, cmag} + {1'b0, cmag, 1'b0};
    trial = {rem_q, nsh_q[47]};
    fits  = trial >= {1'b0, den_q};
    if (neg_q) begin
      qsat = (huge_q || quo_q > 48'h8000_0000_0000) ? 48'h8000_0000_0000 : quo_q;
      qsat = 48'(-qsat);
    end else begin
      qsat = (huge_q || quo_q > 48'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : quo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_item_i.opcode == OP_LOAD) begin
      mem[{in_item_i.node_k, in_item_i.node_j, in_item_i.node_i}] <=
          {in_item_i.coord_z, in_item_i.coord_y, in_item_i.coord_x};
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pos_q <= cpos;
      acc_q <= '0;
      s_q   <= '0;
      for (int r = 0; r < 10; r++) res_q[r] <= '0;
    end
    case (state_q)
      ST_T_RP:  xf_q <= sel_comp(rdata_q, f_c);
      ST_T_RM:  sp_q <= sel_comp(rdata_q, s_c);
      ST_T_DIF: d_q  <= {sp_q[31], sp_q} - {rdata_q_bit(s_c), sel_comp(rdata_q, s_c)};
      ST_T_MUL: prod_q <= mul_a * mul_b;
      ST_T_ACC: acc_q <= tneg ? acc_q - prod_q[67:0] : acc_q + prod_q[67:0];
      ST_D_RM:  sp_q <= sel_comp(rdata_q, comp_q);
      ST_D_DIF: d_q  <= {sp_q[31], sp_q} -
                        {rdata_q_bit(comp_q), sel_comp(rdata_q, comp_q)};
      ST_D_ML: begin
        prod_q       <= mul_a * mul_b;
        cof_q[n_q]   <= acc_q;
      end
      ST_D_MH: begin
        prod_q <= mul_a * mul_b;
        s_q    <= s_q + {{35{prod_q[69]}}, prod_q};
      end
      ST_D_SA: begin
        s_q   <= s_q + {prod_q[69], prod_q, 34'b0};
        acc_q <= '0;
      end
      ST_V_SET: begin
        den_q <= {smag, 1'b0};
        if (vi_q == 4'd0) begin
          num_q <= (112'd3 << 77) + {7'b0, smag};
          neg_q <= s_q[104];
        end else begin
          num_q <= {c3, 42'b0} + {7'b0, smag};
          neg_q <= cur_c[67] ^ s_q[104];
        end
      end
      ST_V_CHK: begin
        huge_q <= {42'b0, num_q[111:48]} >= den_q;
        rem_q  <= {42'b0, num_q[111:48]};
        nsh_q  <= num_q[47:0];
      end
      ST_V_IT: begin
        rem_q <= fits ? 106'(trial - {1'b0, den_q}) : trial[105:0];
        quo_q <= {quo_q[46:0], fits};
        nsh_q <= {nsh_q[46:0], 1'b0};
      end
      ST_V_FIN: res_q[vi_q] <= qsat;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dim_q[0]    <= 6'd32;
      dim_q[1]    <= 6'd32;
      dim_q[2]    <= 6'd32;
      ax_q        <= '0;
      comp_q      <= '0;
      t_q         <= '0;
      n_q         <= '0;
      vi_q        <= '0;
      cnt_q       <= '0;
      stat_q      <= STAT_OK;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_DIM_X: dim_q[0] <= cfg_data_i;
          REG_DIM_Y: dim_q[1] <= cfg_data_i;
          REG_DIM_Z: dim_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      // In the finishing state an accepted item is replaced by the next one below.
      if (out_acc && state_q != ST_DONE) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_acc && in_item_i.opcode == OP_QUERY) begin
            ax_q   <= '0;
            comp_q <= '0;
            t_q    <= '0;
            n_q    <= '0;
            if (oor) begin
              stat_q  <= STAT_RANGE;
              state_q <= ST_DONE;
            end else begin
              stat_q  <= STAT_OK;
              state_q <= ST_T_RQ;
            end
          end
        end
        ST_T_RQ:  state_q <= ST_T_RP;
        ST_T_RP:  state_q <= ST_T_RM;
        ST_T_RM:  state_q <= ST_T_DIF;
        ST_T_DIF: state_q <= ST_T_MUL;
        ST_T_MUL: state_q <= ST_T_ACC;
        ST_T_ACC: begin
          t_q <= t_q + 3'd1;
          state_q <= (t_q == 3'd7) ? ST_D_RP : ST_T_RQ;
        end
        ST_D_RP:  state_q <= ST_D_RM;
        ST_D_RM:  state_q <= ST_D_DIF;
        ST_D_DIF: state_q <= ST_D_ML;
        ST_D_ML:  state_q <= ST_D_MH;
        ST_D_MH:  state_q <= ST_D_SA;
        ST_D_SA: begin
          n_q <= n_q + 4'd1;
          if (comp_q == 2'd2) begin
            comp_q <= 2'd0;
            ax_q   <= ax_q + 2'd1;
            state_q <= (ax_q == 2'd2) ? ST_ZCHK : ST_T_RQ;
          end else begin
            comp_q  <= comp_q + 2'd1;
            state_q <= ST_T_RQ;
          end
        end
        ST_ZCHK: begin
          vi_q <= '0;
          if (s_q == '0) begin
            stat_q  <= STAT_DEGEN;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_V_SET;
          end
        end
        ST_V_SET: state_q <= ST_V_CHK;
        ST_V_CHK: begin
          cnt_q   <= '0;
          state_q <= ST_V_IT;
        end
        ST_V_IT: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd47) state_q <= ST_V_FIN;
        end
        ST_V_FIN: begin
          vi_q    <= vi_q + 4'd1;
          state_q <= (vi_q == 4'd9) ? ST_DONE : ST_V_SET;
        end
        ST_DONE: begin
          // The finished item waits here until the output register is free.
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q        <= 1'b1;
            out_q.inv_jacobian <= res_q[0];
            out_q.xi_dx        <= res_q[1];
            out_q.xi_dy        <= res_q[2];
            out_q.xi_dz        <= res_q[3];
            out_q.eta_dx       <= res_q[4];
            out_q.eta_dy       <= res_q[5];
            out_q.eta_dz       <= res_q[6];
            out_q.zeta_dx      <= res_q[7];
            out_q.zeta_dy      <= res_q[8];
            out_q.zeta_dz      <= res_q[9];
            out_q.status       <= stat_q;
            state_q            <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
